// ----- sv/ghd_pkg.sv -----
// ----------------------------------------------------------------------------
// ghd_pkg
// Types and constants shared by the Gaussian half-size downsampler modules.
// ----------------------------------------------------------------------------
package ghd_pkg;

	localparam int CHANNELS           = 4;
	localparam int TAPS               = 5;
	localparam int ROWS_KEPT          = 5;
	localparam int IN_BITS            = 16;
	localparam int OUT_BITS           = 16;
	localparam int WIDTH_REG_BITS     = 12;
	localparam int HEIGHT_REG_BITS    = 13;
	localparam int ROW_BITS           = 12;
	localparam int MAX_HEIGHT         = 4096;
	localparam int OCOL_BITS          = 10;
	localparam int OROW_BITS          = 11;
	localparam int ADDR_BITS          = 3;
	localparam int DATA_BITS          = 32;
	localparam int ITEM_QUEUE_DEPTH   = 4;
	localparam int RESULT_QUEUE_DEPTH = 8;
	localparam int ROUND_BIAS         = 200;
	localparam int DIV_SHIFT          = 4;
	localparam int DIV_REST           = 25;

	// Separable 1-5-8-5-1 weights per axis; the 5x5 weight sum is 400.
	localparam logic [3:0] TAP_W [TAPS] = '{4'd1, 4'd5, 4'd8, 4'd5, 4'd1};

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [2:0] tap_idx_t;

	typedef struct packed {
		logic     cur;
		tap_idx_t bank;
	} row_tap_t;

	typedef struct packed {
		logic                         trig;
		tap_idx_t                     slot;
		row_tap_t [TAPS-1:0]          row_tap;
		tap_idx_t [TAPS-1:0]          col_dlt;
		logic [OCOL_BITS-1:0]         ox;
		logic [OROW_BITS-1:0]         oy;
		logic                         frame_end;
	} item_ctl_t;

	typedef struct packed {
		logic [CHANNELS-1:0][OUT_BITS-1:0] chan;
		logic [OCOL_BITS-1:0]              col;
		logic [OROW_BITS-1:0]              row;
		logic                              frame_end;
	} result_t;

	function automatic tap_idx_t slot_inc(input tap_idx_t s);
		tap_idx_t n;
		if (s == tap_idx_t'(ROWS_KEPT - 1)) begin
			n = '0;
		end else begin
			n = s + tap_idx_t'(1);
		end
		return n;
	endfunction

	// Line store slot of the row that lies d rows above the row in slot s.
	function automatic tap_idx_t slot_back(input tap_idx_t s, input tap_idx_t d);
		logic [3:0] t;
		t = {1'b0, s} + 4'(ROWS_KEPT) - {1'b0, d};
		if (t >= 4'(ROWS_KEPT)) begin
			t = t - 4'(ROWS_KEPT);
		end
		return t[2:0];
	endfunction

endpackage

// ----- sv/ghd_fifo.sv -----
// ----------------------------------------------------------------------------
// ghd_fifo
// Small first-word-fall-through queue with an occupancy count.
// ----------------------------------------------------------------------------
module ghd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PTR = $clog2(DEPTH),
	localparam int CNT = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic [CNT-1:0]   count
);
	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR-1:0]   wr_ptr_q;
	logic [PTR-1:0]   rd_ptr_q;
	logic [CNT-1:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = store_q[rd_ptr_q];
	assign count      = count_q;
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT'(1);
			end
		end
	end
endmodule

// ----- sv/ghd_front.sv -----
// ----------------------------------------------------------------------------
// ghd_front
// Tracks the source position and classifies each pixel: output trigger,
// line store slot and the clamped tap offsets of the 5x5 window.
// ----------------------------------------------------------------------------
module ghd_front #(
	parameter int MAX_WIDTH   = 2048,
	parameter int SAMPLE_BITS = 16,
	localparam int AW = $clog2(MAX_WIDTH),
	localparam int PW = 4 * SAMPLE_BITS
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            fire,
	input  logic [ghd_pkg::CHANNELS-1:0][ghd_pkg::IN_BITS-1:0] chan_in,
	input  logic                                            frame_start,
	input  logic [ghd_pkg::WIDTH_REG_BITS-1:0]              width_reg,
	input  logic [ghd_pkg::HEIGHT_REG_BITS-1:0]             height_reg,
	output ghd_pkg::item_ctl_t                              ctl,
	output logic [AW-1:0]                                   col,
	output logic [PW-1:0]                                   pix
);
	import ghd_pkg::*;

	localparam int RW = ROW_BITS;

	logic [AW-1:0]   src_col_q;
	logic [RW-1:0]   src_row_q;
	tap_idx_t        slot_q;

	logic [AW:0]     w;
	logic [RW:0]     h;
	logic [AW:0]     col0;
	logic [RW:0]     row0;
	logic [RW:0]     row1;
	tap_idx_t        slot0;
	tap_idx_t        slot1;
	tap_idx_t        slot;
	logic [AW-1:0]   c;
	logic [RW-1:0]   r;
	logic [AW-1:0]   nc;
	logic [RW-1:0]   nr;
	tap_idx_t        nslot;
	logic [AW-1:0]   half_w;
	logic [RW-1:0]   half_h;
	logic            trig_x;
	logic            trig_y;
	logic [AW-1:0]   ox;
	logic [RW-1:0]   oy;

	always_comb begin
		if (width_reg == '0) begin
			w = (AW+1)'(1);
		end else if (14'(width_reg) > 14'(MAX_WIDTH)) begin
			w = (AW+1)'(MAX_WIDTH);
		end else begin
			w = (AW+1)'(width_reg);
		end
		if (height_reg == '0) begin
			h = (RW+1)'(1);
		end else if (height_reg > HEIGHT_REG_BITS'(MAX_HEIGHT)) begin
			h = (RW+1)'(MAX_HEIGHT);
		end else begin
			h = height_reg;
		end
	end

	// Position of this pixel, with the wrap of a position left past the image.
	always_comb begin
		col0  = frame_start ? '0 : {1'b0, src_col_q};
		row0  = frame_start ? '0 : {1'b0, src_row_q};
		slot0 = frame_start ? '0 : slot_q;
		row1  = row0;
		slot1 = slot0;
		c     = col0[AW-1:0];
		if (col0 >= w) begin
			c     = '0;
			row1  = row0 + (RW+1)'(1);
			slot1 = slot_inc(slot0);
		end
		r    = row1[RW-1:0];
		slot = slot1;
		if (row1 >= h) begin
			r    = '0;
			slot = '0;
		end
		nc    = c + AW'(1);
		nr    = r;
		nslot = slot;
		if ({1'b0, c} + (AW+1)'(1) >= w) begin
			nc = '0;
			if ({1'b0, r} + (RW+1)'(1) >= h) begin
				nr    = '0;
				nslot = '0;
			end else begin
				nr    = r + RW'(1);
				nslot = slot_inc(slot);
			end
		end
	end

	always_comb begin
		half_w = w[AW:1];
		half_h = h[RW:1];
		trig_x = (half_w != '0) &&
			(({1'b0, c} == w - (AW+1)'(1)) || (c >= AW'(2) && !c[0]));
		trig_y = (half_h != '0) &&
			(({1'b0, r} == h - (RW+1)'(1)) || (r >= RW'(2) && !r[0]));
		if ({1'b0, c} == w - (AW+1)'(1)) begin
			ox = half_w - AW'(1);
		end else begin
			ox = {1'b0, c[AW-1:1]} - AW'(1);
		end
		if ({1'b0, r} == h - (RW+1)'(1)) begin
			oy = half_h - RW'(1);
		end else begin
			oy = {1'b0, r[RW-1:1]} - RW'(1);
		end
	end

	// Clamped tap offsets, counted back from the current column and row.
	always_comb begin
		logic [AW+2:0] tx;
		logic [AW+1:0] cx_c;
		logic [RW+2:0] ty;
		logic [RW+1:0] cy_c;
		tap_idx_t      dy;
		ctl.trig      = trig_x && trig_y;
		ctl.slot      = slot;
		ctl.ox        = OCOL_BITS'(ox);
		ctl.oy        = OROW_BITS'(oy);
		ctl.frame_end = (ox == half_w - AW'(1)) && (oy == half_h - RW'(1));
		for (int i = 0; i < TAPS; i++) begin
			tx = (AW+3)'({ox, 1'b0}) + (AW+3)'(i) - (AW+3)'(2);
			if (tx[AW+2]) begin
				cx_c = '0;
			end else if (tx[AW+1:0] > (AW+2)'(w) - (AW+2)'(1)) begin
				cx_c = (AW+2)'(w) - (AW+2)'(1);
			end else begin
				cx_c = tx[AW+1:0];
			end
			ctl.col_dlt[i] = 3'((AW+2)'(c) - cx_c);
			ty = (RW+3)'({oy, 1'b0}) + (RW+3)'(i) - (RW+3)'(2);
			if (ty[RW+2]) begin
				cy_c = '0;
			end else if (ty[RW+1:0] > (RW+2)'(h) - (RW+2)'(1)) begin
				cy_c = (RW+2)'(h) - (RW+2)'(1);
			end else begin
				cy_c = ty[RW+1:0];
			end
			dy = 3'((RW+2)'(r) - cy_c);
			ctl.row_tap[i].cur  = (dy == '0);
			ctl.row_tap[i].bank = slot_back(slot, dy);
		end
	end

	always_comb begin
		col = c;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			pix[ch*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(chan_in[ch]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			slot_q    <= '0;
		end else if (fire) begin
			src_col_q <= nc;
			src_row_q <= nr;
			slot_q    <= nslot;
		end
	end
endmodule

// ----- sv/ghd_back.sv -----
// ----------------------------------------------------------------------------
// ghd_back
// Line store, vertical and horizontal 1-5-8-5-1 sums and the rounded
// division by 400. Takes one pixel a cycle but holds a triggering item until
// a result slot is reserved for it; never stalls once an item is taken.
// ----------------------------------------------------------------------------
module ghd_back #(
	parameter int MAX_WIDTH   = 2048,
	parameter int SAMPLE_BITS = 16,
	localparam int AW  = $clog2(MAX_WIDTH),
	localparam int PW  = 4 * SAMPLE_BITS,
	localparam int OCW = $clog2(ghd_pkg::RESULT_QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_pop,
	input  ghd_pkg::item_ctl_t  item_ctl,
	input  logic [AW-1:0]       item_col,
	input  logic [PW-1:0]       item_pix,
	input  logic [OCW-1:0]      out_count,
	output logic                res_push,
	output ghd_pkg::result_t    res
);
	import ghd_pkg::*;

	localparam int S  = SAMPLE_BITS;
	localparam int VB = S + 5;
	localparam int HB = S + 9;
	localparam int YB = S + 5;
	localparam int MW = YB - 4;
	localparam int QB = S + 1;
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << YB) / DIV_REST);

	logic [PW-1:0] bank_mem [ROWS_KEPT][MAX_WIDTH];
	logic [PW-1:0] rd_s1 [ROWS_KEPT];
	logic [PW-1:0] pix_s1;
	item_ctl_t     ctl_s1;
	logic          vld_s1;

	logic [VB-1:0] v_s2 [CHANNELS];
	logic [VB-1:0] hist_q [TAPS-1][CHANNELS];
	item_ctl_t     ctl_s2;
	logic          vld_s2;

	logic [YB-1:0] y_s3 [CHANNELS];
	item_ctl_t     ctl_s3;
	logic          vld_s3;

	logic [QB-1:0] q0_s4 [CHANNELS];
	logic [YB-1:0] y_s4 [CHANNELS];
	item_ctl_t     ctl_s4;
	logic          vld_s4;

	logic [3:0]    inflight_q;
	logic [4:0]    reserved;
	logic [VB-1:0] v_sum [CHANNELS];
	logic [YB-1:0] y_val [CHANNELS];

	assign reserved = 5'(out_count) + 5'(inflight_q);
	assign item_pop = item_valid &&
		(!item_ctl.trig || reserved < 5'(RESULT_QUEUE_DEPTH));

	// One bank per kept row: the current pixel is written into its own
	// row's bank while every bank is read at the same column.
	for (genvar b = 0; b < ROWS_KEPT; b++) begin : g_bank
		always_ff @(posedge clk) begin
			if (item_pop) begin
				if (item_ctl.slot == tap_idx_t'(b)) begin
					bank_mem[b][item_col] <= item_pix;
				end
				rd_s1[b] <= bank_mem[b][item_col];
			end
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= item_pix;
		ctl_s1 <= item_ctl;
	end

	// Vertical sum; a tap on the current row takes the arriving pixel.
	always_comb begin
		logic [PW-1:0] src;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			v_sum[ch] = '0;
		end
		for (int j = 0; j < TAPS; j++) begin
			src = ctl_s1.row_tap[j].cur ? pix_s1 : rd_s1[ctl_s1.row_tap[j].bank];
			for (int ch = 0; ch < CHANNELS; ch++) begin
				v_sum[ch] = v_sum[ch] + VB'(TAP_W[j]) * VB'(src[ch*S +: S]);
			end
		end
	end

	always_ff @(posedge clk) begin
		v_s2   <= v_sum;
		ctl_s2 <= ctl_s1;
	end

	// Horizontal sum over the last five column sums of this row.
	always_comb begin
		logic [HB-1:0] hsum;
		logic [VB-1:0] tap_v;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			hsum = '0;
			for (int i = 0; i < TAPS; i++) begin
				tap_v = v_s2[ch];
				for (int k = 1; k < TAPS; k++) begin
					if (ctl_s2.col_dlt[i] == tap_idx_t'(k)) begin
						tap_v = hist_q[k-1][ch];
					end
				end
				hsum = hsum + HB'(TAP_W[i]) * HB'(tap_v);
			end
			hsum      = hsum + HB'(ROUND_BIAS);
			y_val[ch] = YB'(hsum >> DIV_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			hist_q[0] <= v_s2;
			for (int k = 1; k < TAPS - 1; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
		end
		y_s3   <= y_val;
		ctl_s3 <= ctl_s2;
	end

	// Division by 25 through the reciprocal; the estimate is at most one low.
	always_ff @(posedge clk) begin
		logic [YB+MW-1:0] prod;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			prod      = (YB+MW)'(y_s3[ch]) * (YB+MW)'(RECIP);
			q0_s4[ch] <= QB'(prod >> YB);
		end
		y_s4   <= y_s3;
		ctl_s4 <= ctl_s3;
	end

	always_comb begin
		logic [YB-1:0] rem;
		logic [QB-1:0] q;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			rem = y_s4[ch] - YB'(q0_s4[ch]) * YB'(DIV_REST);
			q   = (rem >= YB'(DIV_REST)) ? q0_s4[ch] + QB'(1) : q0_s4[ch];
			res.chan[ch] = OUT_BITS'(q);
		end
		res.col       = ctl_s4.ox;
		res.row       = ctl_s4.oy;
		res.frame_end = ctl_s4.frame_end;
	end

	assign res_push = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			inflight_q <= '0;
		end else begin
			vld_s1 <= item_pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 && ctl_s2.trig;
			vld_s4 <= vld_s3;
			if (item_pop && item_ctl.trig && !vld_s4) begin
				inflight_q <= inflight_q + 4'd1;
			end else if (vld_s4 && !(item_pop && item_ctl.trig)) begin
				inflight_q <= inflight_q - 4'd1;
			end
		end
	end
endmodule

// ----- sv/gaussian_half_downsample.sv -----
// ----------------------------------------------------------------------------
// gaussian_half_downsample
// Gaussian pyramid reduce: 5x5 1-5-8-5-1 filter and 2:1 decimation of a
// four-channel raster stream.
//
// Pixels enter in raster order on in_valid/in_ready, one transaction per
// pixel; frame_start on a pixel places it at position (0,0). Half-size
// pixels leave on out_valid/out_ready with their column, row and a
// frame_end flag on the last one of the frame.
// Up to one pixel is taken per clock. out_valid for a result rises after the
// pixel completing its window passes the item queue and stages s1 to s4;
// the pipeline after the item queue runs one pixel a cycle, so the
// sustained rate is one pixel per clock while the receiver keeps up.
// When the receiver stalls the result queue fills, triggering pixels wait
// in the four-entry item queue and in_ready falls once that queue is full.
// Reset clears position, queues and pipeline; the line store holds no valid
// data until rows are written. The user writes image_width and image_height
// at APB byte addresses 0 and 4 only while idle; the block does not check it.
// ----------------------------------------------------------------------------
module gaussian_half_downsample #(
	parameter int MAX_WIDTH   = 2048,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ghd_pkg::ADDR_BITS-1:0]        paddr,
	input  logic [ghd_pkg::DATA_BITS-1:0]        pwdata,
	output logic [ghd_pkg::DATA_BITS-1:0]        prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ghd_pkg::IN_BITS-1:0]          chan0_in,
	input  logic [ghd_pkg::IN_BITS-1:0]          chan1_in,
	input  logic [ghd_pkg::IN_BITS-1:0]          chan2_in,
	input  logic [ghd_pkg::IN_BITS-1:0]          chan3_in,
	input  logic                                 frame_start,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [ghd_pkg::OUT_BITS-1:0]         chan0_out,
	output logic [ghd_pkg::OUT_BITS-1:0]         chan1_out,
	output logic [ghd_pkg::OUT_BITS-1:0]         chan2_out,
	output logic [ghd_pkg::OUT_BITS-1:0]         chan3_out,
	output logic [ghd_pkg::OCOL_BITS-1:0]        out_col,
	output logic [ghd_pkg::OROW_BITS-1:0]        out_row,
	output logic                                 frame_end
);
	import ghd_pkg::*;

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int PW  = 4 * SAMPLE_BITS;
	localparam int IW  = $bits(item_ctl_t) + AW + PW;
	localparam int RSW = $bits(result_t);
	localparam int ICW = $clog2(ITEM_QUEUE_DEPTH + 1);
	localparam int OCW = $clog2(RESULT_QUEUE_DEPTH + 1);

	logic [WIDTH_REG_BITS-1:0]  width_q;
	logic [HEIGHT_REG_BITS-1:0] height_q;
	logic                       fire;
	item_ctl_t                  f_ctl;
	logic [AW-1:0]              f_col;
	logic [PW-1:0]              f_pix;
	logic                       iq_valid;
	logic                       iq_pop;
	logic [IW-1:0]              iq_data;
	logic [ICW-1:0]             iq_count;
	item_ctl_t                  b_ctl;
	logic [AW-1:0]              b_col;
	logic [PW-1:0]              b_pix;
	logic                       res_push;
	result_t                    res;
	logic                       rq_ready;
	logic [RSW-1:0]             rq_data;
	logic [OCW-1:0]             rq_count;
	result_t                    out_res;
	logic [CHANNELS-1:0][IN_BITS-1:0] chan_in;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_BITS'(2048);
			height_q <= HEIGHT_REG_BITS'(2048);
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[2]))
				REG_IMAGE_WIDTH: begin
					width_q <= pwdata[WIDTH_REG_BITS-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= pwdata[HEIGHT_REG_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_IMAGE_WIDTH:  prdata = DATA_BITS'(width_q);
			REG_IMAGE_HEIGHT: prdata = DATA_BITS'(height_q);
			default:          prdata = '0;
		endcase
	end

	assign chan_in = {chan3_in, chan2_in, chan1_in, chan0_in};
	assign fire    = in_valid && in_ready;

	ghd_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.chan_in     (chan_in),
		.frame_start (frame_start),
		.width_reg   (width_q),
		.height_reg  (height_q),
		.ctl         (f_ctl),
		.col         (f_col),
		.pix         (f_pix)
	);

	ghd_fifo #(
		.WIDTH (IW),
		.DEPTH (ITEM_QUEUE_DEPTH)
	) u_item_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fire),
		.push_data  ({f_ctl, f_col, f_pix}),
		.push_ready (in_ready),
		.pop_valid  (iq_valid),
		.pop        (iq_pop),
		.pop_data   (iq_data),
		.count      (iq_count)
	);

	assign {b_ctl, b_col, b_pix} = iq_data;

	ghd_back #(
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (iq_valid && (iq_count != '0)),
		.item_pop   (iq_pop),
		.item_ctl   (b_ctl),
		.item_col   (b_col),
		.item_pix   (b_pix),
		.out_count  (rq_count),
		.res_push   (res_push),
		.res        (res)
	);

	// The back end reserves a slot before it takes a triggering pixel,
	// so a push never meets a full result queue.
	ghd_fifo #(
		.WIDTH (RSW),
		.DEPTH (RESULT_QUEUE_DEPTH)
	) u_result_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_push),
		.push_data  (res),
		.push_ready (rq_ready),
		.pop_valid  (out_valid),
		.pop        (out_ready && rq_ready | out_ready),
		.pop_data   (rq_data),
		.count      (rq_count)
	);

	assign out_res   = rq_data;
	assign chan0_out = out_res.chan[0];
	assign chan1_out = out_res.chan[1];
	assign chan2_out = out_res.chan[2];
	assign chan3_out = out_res.chan[3];
	assign out_col   = out_res.col;
	assign out_row   = out_res.row;
	assign frame_end = out_res.frame_end;
endmodule
